// ===== hw/rtl/sacn_pkg.sv =====
package sacn_pkg;

    localparam int SETS     = 256;
    localparam int WAYS     = 4;
    localparam int ADDR_W   = 32;
    localparam int TAG_W    = 32;
    localparam int MASK_W   = 32;
    localparam int CNT_W    = 32;

    // floor(log2(n)), number of index bits gathered from the address
    function automatic int floor_log2(input int n);
        int b;
        int v;
        b = 0;
        v = n;
        while (v > 1) begin
            v = v >> 1;
            b = b + 1;
        end
        return b;
    endfunction

    localparam int IDX_BITS = floor_log2(SETS);
    localparam int SET_W    = (IDX_BITS > 0) ? IDX_BITS : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAYS_W   = $clog2(WAYS + 1);
    localparam int POS_W    = $clog2(MASK_W + 1);

    // configuration register indexes
    localparam logic [1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [1:0] CFG_INDEX_MASK  = 2'd1;
    localparam logic [1:0] CFG_WAYS_IN_USE = 2'd2;

    // one set: flags and tags of every way
    typedef struct packed {
        logic [WAYS-1:0]             valid;
        logic [WAYS-1:0]             nru;
        logic [WAYS-1:0][TAG_W-1:0]  tag;
    } t_line;

    // lookup decision for one access
    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
        t_line            line;
    } t_sel;

endpackage

// ===== hw/rtl/set_assoc_cache_nru_lookup_unit.sv =====
// Set-associative tag lookup with NRU replacement, 256 sets of 4 ways.
// Raise start with an address while busy is low; exactly one result follows
// on o_result_strobe, and busy drops in the same cycle the strobe rises, so
// a new access can be issued then; none is taken while one is in flight.
// The result is shown for one cycle only and cannot be stalled: the receiver
// must take it. The steps are set index gathering with the registered read
// of the set's line memory (ST_IDX), the compare / victim pick with
// write-back (ST_CMP), and the result register. After reset the unit
// clears valid and sets NRU flags, one set per cycle, with busy high.
// Configuration writes are always taken (o_cfg_ready is tied high) and should
// only be issued while no access is in flight; index 0 is offset_bits,
// 1 is index_mask, 2 is ways_in_use, 3 is ignored. The tag store is not
// flushed when registers change. The miss count saturates at all ones.
module set_assoc_cache_nru_lookup_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_address,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_result_strobe,
    output logic        o_is_hit,
    output logic [7:0]  o_set_index,
    output logic [1:0]  o_way_index,
    output logic [31:0] o_miss_total
);
    import sacn_pkg::*;

    localparam logic [1:0] ST_CLR  = 2'd0;  // post-reset flag sweep
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_IDX  = 2'd2;  // gather set, issue line read
    localparam logic [1:0] ST_CMP  = 2'd3;  // compare, pick victim, write back

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [SET_W-1:0]  r_clr_idx;
    logic [ADDR_W-1:0] r_addr;
    logic [TAG_W-1:0]  r_tag;
    logic [SET_W-1:0]  r_set;
    logic [4:0]        r_offset_bits;
    logic [MASK_W-1:0] r_index_mask;
    logic [2:0]        r_ways_in_use;
    logic [CNT_W-1:0]  r_miss_total;
    logic [CNT_W-1:0]  n_miss_total;

    logic              accept;
    logic [SET_W-1:0]  gather_set;
    t_line             rd_line;
    t_line             clr_line;
    t_sel              sel;
    logic              wr_en;
    logic [SET_W-1:0]  wr_set;
    t_line             wr_line;

    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // ---- configuration registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= 5'd0;
            r_index_mask  <= MASK_W'(255);
            r_ways_in_use <= 3'd4;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data[4:0];
                CFG_INDEX_MASK:  r_index_mask  <= i_cfg_data;
                CFG_WAYS_IN_USE: r_ways_in_use <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // ---- sequencer ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR:  if (r_clr_idx == SET_W'(SETS - 1)) n_state = ST_IDLE;
            ST_IDLE: if (accept) n_state = ST_IDX;
            ST_IDX:  n_state = ST_CMP;
            ST_CMP:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLR) begin
                r_clr_idx <= r_clr_idx + SET_W'(1);
            end
        end
    end

    // address and tag are captured on the accepting edge
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= i_address;
            r_tag  <= TAG_W'(i_address >> r_offset_bits);
        end
        if (r_state == ST_IDX) begin
            r_set <= gather_set;
        end
    end

    sacn_index_gather u_gather (
        .i_addr (r_addr),
        .i_mask (r_index_mask),
        .o_set  (gather_set)
    );

    // ---- line memory: read in ST_IDX, data valid in ST_CMP ----
    // A write in ST_CMP lands before the next access can read (its read is
    // issued in ST_IDX, which follows ST_IDLE), so no forwarding is needed.
    always_comb begin
        clr_line       = '0;
        clr_line.nru   = '1;
        wr_en          = 1'b0;
        wr_set         = r_set;
        wr_line        = sel.line;
        if (r_state == ST_CLR) begin
            wr_en   = 1'b1;
            wr_set  = r_clr_idx;
            wr_line = clr_line;
        end else if (r_state == ST_CMP && !sel.hit) begin
            wr_en = 1'b1;
        end
    end

    sacn_line_store u_store (
        .i_clk     (i_clk),
        .i_rd_en   (r_state == ST_IDX),
        .i_rd_set  (gather_set),
        .i_wr_en   (wr_en),
        .i_wr_set  (wr_set),
        .i_wr_line (wr_line),
        .o_rd_line (rd_line)
    );

    sacn_way_select u_select (
        .i_line        (rd_line),
        .i_tag         (r_tag),
        .i_ways_in_use (r_ways_in_use),
        .o_sel         (sel)
    );

    // ---- miss counter, saturating ----
    always_comb begin
        n_miss_total = r_miss_total;
        if (r_state == ST_CMP && !sel.hit && r_miss_total != '1) begin
            n_miss_total = r_miss_total + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss_total <= '0;
        end else begin
            r_miss_total <= n_miss_total;
        end
    end

    // ---- result register: one-cycle strobe ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_strobe <= 1'b0;
        end else begin
            o_result_strobe <= (r_state == ST_CMP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CMP) begin
            o_is_hit     <= sel.hit;
            o_set_index  <= 8'(r_set);
            o_way_index  <= 2'(sel.way);
            o_miss_total <= n_miss_total;
        end
    end

endmodule

// ===== hw/rtl/sacn_index_gather.sv =====
module sacn_index_gather (
    input  logic [sacn_pkg::ADDR_W-1:0] i_addr,
    input  logic [sacn_pkg::MASK_W-1:0] i_mask,
    output logic [sacn_pkg::SET_W-1:0]  o_set
);
    import sacn_pkg::*;

    // Each mask bit knows its rank from a prefix popcount; ranks below
    // IDX_BITS land in the set index.
    always_comb begin
        logic [POS_W-1:0] pos;
        o_set = '0;
        for (int b = 0; b < MASK_W; b++) begin
            pos = POS_W'($countones(i_mask & ((MASK_W'(1) << b) - MASK_W'(1))));
            for (int k = 0; k < IDX_BITS; k++) begin
                if (i_mask[b] && (pos == POS_W'(k)) && (b < ADDR_W) && i_addr[b]) begin
                    o_set[k] = 1'b1;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/sacn_line_store.sv =====
module sacn_line_store (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [sacn_pkg::SET_W-1:0] i_rd_set,
    input  logic                       i_wr_en,
    input  logic [sacn_pkg::SET_W-1:0] i_wr_set,
    input  sacn_pkg::t_line            i_wr_line,
    output sacn_pkg::t_line            o_rd_line
);
    import sacn_pkg::*;

    logic [WAYS*TAG_W-1:0] r_tag_mem  [SETS];
    logic [2*WAYS-1:0]     r_flag_mem [SETS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_tag_mem[i_wr_set]  <= i_wr_line.tag;
            r_flag_mem[i_wr_set] <= {i_wr_line.valid, i_wr_line.nru};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_line.tag                  <= r_tag_mem[i_rd_set];
            {o_rd_line.valid, o_rd_line.nru} <= r_flag_mem[i_rd_set];
        end
    end

endmodule

// ===== hw/rtl/sacn_way_select.sv =====
module sacn_way_select (
    input  sacn_pkg::t_line             i_line,
    input  logic [sacn_pkg::TAG_W-1:0]  i_tag,
    input  logic [2:0]                  i_ways_in_use,
    output sacn_pkg::t_sel              o_sel
);
    import sacn_pkg::*;

    logic [WAYS_W-1:0] nw;
    logic [WAYS-1:0]   used;
    logic [WAYS-1:0]   hit_vec;
    logic [WAYS-1:0]   cand;
    logic [WAYS-1:0]   nru_base;

    always_comb begin
        if (i_ways_in_use == 3'd0) begin
            nw = WAYS_W'(1);
        end else if (WAYS_W'(i_ways_in_use) > WAYS_W'(WAYS) || i_ways_in_use > 3'(WAYS)) begin
            nw = WAYS_W'(WAYS);
        end else begin
            nw = WAYS_W'(i_ways_in_use);
        end
        for (int w = 0; w < WAYS; w++) begin
            used[w]    = (WAYS_W'(w) < nw);
            hit_vec[w] = used[w] && i_line.valid[w] && (i_line.tag[w] == i_tag);
        end
        // no candidate left: refill all used NRU bits, victim falls to way 0
        nru_base = (|(i_line.nru & used)) ? i_line.nru : (i_line.nru | used);
        cand     = nru_base & used;
    end

    always_comb begin
        o_sel.hit  = |hit_vec;
        o_sel.way  = '0;
        o_sel.line = i_line;
        if (|hit_vec) begin
            for (int w = WAYS - 1; w >= 0; w--) begin
                if (hit_vec[w]) begin
                    o_sel.way = WAY_W'(w);
                end
            end
        end else begin
            for (int w = WAYS - 1; w >= 0; w--) begin
                if (cand[w]) begin
                    o_sel.way = WAY_W'(w);
                end
            end
            o_sel.line.nru             = nru_base;
            o_sel.line.nru[o_sel.way]   = 1'b0;
            o_sel.line.valid[o_sel.way] = 1'b1;
            o_sel.line.tag[o_sel.way]   = i_tag;
        end
    end

endmodule

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sacn_pkg::*;

    // register index 3 is decoded by nobody; writes to it must change nothing
    localparam logic [1:0] CFG_SPARE = 2'd3;

    localparam int PHASES       = 12;   // random phases, one register setting each
    localparam int PHASE_ITEMS  = 150;  // lookups per random phase
    localparam int POOL         = 12;   // hot addresses per phase, keeps hit rate up
    localparam int DRAIN_CYCLES = 6;    // extra wait once every lookup is back
    localparam int MAX_SHOWN    = 10;

    // one lookup result as seen on the result ports
    typedef struct packed {
        logic             hit;
        logic [SET_W-1:0] set_idx;
        logic [WAY_W-1:0] way;
        logic [CNT_W-1:0] misses;
    } t_lookup;

    typedef enum logic {ROW_ACCESS, ROW_WRITE} t_row_kind;

    // directed stimulus row: a lookup or a register write
    typedef struct {
        t_row_kind   kind;
        logic [1:0]  reg_idx;
        logic [31:0] value;
        bit          typed;   // result typed in by hand, not taken from the predictor
        t_lookup     want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_address;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        o_result_strobe;
    logic        o_is_hit;
    logic [7:0]  o_set_index;
    logic [1:0]  o_way_index;
    logic [31:0] o_miss_total;

    // shadow of the cache: registers, tags, valid and NRU flags, miss count
    logic [4:0]        cur_offset;
    logic [MASK_W-1:0] cur_mask;
    logic [2:0]        cur_ways;
    logic [TAG_W-1:0]  tag_mem [SETS][WAYS];
    bit                vld_mem [SETS][WAYS];
    bit                nru_mem [SETS][WAYS];
    logic [CNT_W-1:0]  miss_cnt;

    t_lookup     lookups_owed[$];   // predicted results, oldest first
    t_row        plan[$];
    logic [31:0] hot_addr [POOL];
    int          bad = 0;
    t_lookup     seen;
    t_lookup     owed;

    always #4 i_clk = ~i_clk;

    set_assoc_cache_nru_lookup_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_address       (i_address),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_result_strobe (o_result_strobe),
        .o_is_hit        (o_is_hit),
        .o_set_index     (o_set_index),
        .o_way_index     (o_way_index),
        .o_miss_total    (o_miss_total)
    );

    // Lookup with NRU fill. Set index: first IDX_BITS address bits picked by
    // the mask, low to high; missing high bits read as zero. Only valid
    // entries among the used ways can hit. On a miss the lowest used way with
    // its NRU flag set is filled; if none is set, all used flags are set
    // first, so way 0 is taken.
    function automatic t_lookup lookup_predict(input logic [ADDR_W-1:0] addr);
        t_lookup          r;
        logic [TAG_W-1:0] tag;
        int               set_no;
        int               got;
        int               nw;
        int               w;
        int               b;
        bit               found;
        tag    = addr >> cur_offset;
        set_no = 0;
        got    = 0;
        for (b = 0; b < MASK_W && got < IDX_BITS; b++) begin
            if (cur_mask[b]) begin
                if (addr[b])
                    set_no |= 1 << got;
                got++;
            end
        end
        // ways_in_use of 0 acts as 1, above WAYS acts as WAYS
        nw    = (cur_ways == 0) ? 1 : (cur_ways > WAYS) ? WAYS : cur_ways;
        r.hit = 1'b0;
        r.way = '0;
        for (w = 0; w < nw && !r.hit; w++) begin
            if (vld_mem[set_no][w] && tag_mem[set_no][w] == tag) begin
                r.hit = 1'b1;
                r.way = WAY_W'(w);
            end
        end
        if (!r.hit) begin
            found = 1'b0;
            for (w = 0; w < nw && !found; w++) begin
                if (nru_mem[set_no][w]) begin
                    found = 1'b1;
                    r.way = WAY_W'(w);
                end
            end
            if (!found) begin
                for (w = 0; w < nw; w++)
                    nru_mem[set_no][w] = 1'b1;
                r.way = '0;
            end
            nru_mem[set_no][r.way] = 1'b0;
            tag_mem[set_no][r.way] = tag;
            vld_mem[set_no][r.way] = 1'b1;
            if (miss_cnt != '1)
                miss_cnt++;
        end
        r.set_idx = SET_W'(set_no);
        r.misses  = miss_cnt;
        return r;
    endfunction

    function automatic void add_access(input logic [31:0] addr);
        t_row r;
        r.kind    = ROW_ACCESS;
        r.reg_idx = CFG_OFFSET_BITS;
        r.value   = addr;
        r.typed   = 1'b0;
        r.want    = '0;
        plan.insert(plan.size(), r);
    endfunction

    function automatic void add_checked(input logic [31:0] addr, input logic hit,
                                        input logic [7:0] set_idx, input logic [1:0] way,
                                        input logic [31:0] misses);
        t_row r;
        r.kind    = ROW_ACCESS;
        r.reg_idx = CFG_OFFSET_BITS;
        r.value   = addr;
        r.typed   = 1'b1;
        r.want    = {hit, set_idx, way, misses};
        plan.insert(plan.size(), r);
    endfunction

    function automatic void add_write(input logic [1:0] idx, input logic [31:0] data);
        t_row r;
        r.kind    = ROW_WRITE;
        r.reg_idx = idx;
        r.value   = data;
        r.typed   = 1'b0;
        r.want    = '0;
        plan.insert(plan.size(), r);
    endfunction

    // Present one address and wait for the transfer. Start is left high so a
    // zero gap runs the next lookup back to back; here it is only dropped when a
    // gap is drawn, in the step where the previous transfer was taken.
    task automatic issue_access(input logic [31:0] addr, input bit typed,
                                input t_lookup want);
        int      gap;
        t_lookup guess;
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_address <= addr;
        do @(posedge i_clk); while (busy !== 1'b0);
        guess = lookup_predict(addr);
        if (typed)
            guess = want;
        lookups_owed.insert(lookups_owed.size(), guess);
    endtask

    // Register write; valid stays high so writes can follow back to back,
    // the caller drops it once the group is done.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_OFFSET_BITS: cur_offset = data[4:0];
            CFG_INDEX_MASK:  cur_mask   = data;
            CFG_WAYS_IN_USE: cur_ways   = data[2:0];
            default:         ;
        endcase
    endtask

    // Stop issuing and let every outstanding lookup come back.
    task automatic settle();
        start <= 1'b0;
        while (lookups_owed.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly hot addresses (hits, same-set conflicts), some near misses of
    // them, some fully random.
    function automatic logic [31:0] pick_address();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return hot_addr[$urandom_range(0, POOL - 1)];
        else if (roll < 85)
            return hot_addr[$urandom_range(0, POOL - 1)] ^ (32'd1 << $urandom_range(0, 31));
        else
            return $urandom;
    endfunction

    // Result checker: the strobe marks a transfer at this edge, no stalls.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_result_strobe === 1'b1) begin
            seen = {o_is_hit, o_set_index, o_way_index, o_miss_total};
            if (lookups_owed.size() == 0) begin
                bad++;
                if (bad <= MAX_SHOWN)
                    $display("unexpected result: hit %0d set %0d way %0d misses %0d",
                             seen.hit, seen.set_idx, seen.way, seen.misses);
            end else begin
                owed = lookups_owed.pop_front();
                if (seen.hit !== owed.hit || seen.set_idx !== owed.set_idx ||
                    seen.way !== owed.way || seen.misses !== owed.misses) begin
                    bad++;
                    if (bad <= MAX_SHOWN) begin
                        $write("result wrong: expected hit %0d set %0d way %0d misses %0d",
                               owed.hit, owed.set_idx, owed.way, owed.misses);
                        $display(", got hit %0d set %0d way %0d misses %0d",
                                 seen.hit, seen.set_idx, seen.way, seen.misses);
                    end
                end
            end
        end
    end

    initial begin
        bit          cfg_open;
        logic [4:0]  off;
        logic [31:0] msk;
        logic [2:0]  wy;

        start       = 1'b0;
        i_address   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_OFFSET_BITS;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;

        // shadow reset state
        cur_offset = 5'd0;
        cur_mask   = 32'd255;
        cur_ways   = 3'd4;
        miss_cnt   = '0;
        foreach (vld_mem[s, w]) begin
            vld_mem[s][w] = 1'b0;
            nru_mem[s][w] = 1'b1;
            tag_mem[s][w] = '0;
        end

        // Directed part. First three rows are readable by eye: cold miss,
        // repeat hit, and top set filled at way 0.
        add_checked(32'h0000_0000, 1'b0, 8'd0,   2'd0, 32'd1);
        add_checked(32'h0000_0000, 1'b1, 8'd0,   2'd0, 32'd1);
        add_checked(32'hFFFF_FFFF, 1'b0, 8'd255, 2'd0, 32'd2);
        // fill set 0, then force the NRU flags to wrap
        add_access(32'h0000_0100);
        add_access(32'h0000_0200);
        add_access(32'h0000_0300);
        add_access(32'h0000_0400);
        add_access(32'h0000_0000);
        add_access(32'h0000_0300);
        // single way, then ways field 0 (acts as 1) and 7 (acts as 4)
        add_write(CFG_WAYS_IN_USE, 32'h0000_0001);
        add_access(32'h0000_0000);
        add_write(CFG_WAYS_IN_USE, 32'hFFFF_FFF8);
        add_access(32'h0000_0400);
        add_write(CFG_WAYS_IN_USE, 32'h0000_0007);
        add_access(32'h0000_0300);
        add_write(CFG_SPARE, 32'hA5A5_5A5A);
        // widest offset and empty mask: one-bit tags, everything in set 0
        add_write(CFG_OFFSET_BITS, 32'h0000_001F);
        add_write(CFG_INDEX_MASK, 32'h0000_0000);
        add_access(32'h8000_0000);
        add_access(32'hFFFF_FFFF);
        add_access(32'h7FFF_FFFF);
        // full mask uses only the low bits; old tags still compare
        add_write(CFG_OFFSET_BITS, 32'hFFFF_FFE0);
        add_write(CFG_INDEX_MASK, 32'hFFFF_FFFF);
        add_access(32'hFFFF_FFFF);
        // mask with too few bits: upper set bits stay zero
        add_write(CFG_INDEX_MASK, 32'h8000_0000);
        add_access(32'h8000_0000);
        add_access(32'h0000_1234);
        // split mask, low and high nibbles
        add_write(CFG_INDEX_MASK, 32'hF000_000F);
        add_access(32'hA000_0005);
        add_access(32'h5000_000A);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // flag clearing pass after reset keeps busy high
        do @(posedge i_clk); while (busy !== 1'b0);

        cfg_open = 1'b0;
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                if (!cfg_open)
                    settle();
                write_reg(plan[i].reg_idx, plan[i].value);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) begin
                    i_cfg_valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                issue_access(plan[i].value, plan[i].typed, plan[i].want);
            end
        end

        // Random phases; phase 0 returns to the reset setting. Upper data
        // bits of the narrow registers are random to check they are dropped.
        for (int p = 0; p < PHASES; p++) begin
            settle();
            if (p == 0)
                off = 5'd0;
            else if (p % 4 == 1)
                off = 5'd31;
            else
                off = $urandom_range(0, 31);
            case (p == 0 ? 0 : $urandom_range(0, 5))
                0:       msk = 32'd255;
                1:       msk = 32'd0;
                2:       msk = 32'hFFFF_FFFF;
                3:       msk = $urandom;
                4:       msk = $urandom & $urandom & $urandom;
                default: msk = 32'hFF << $urandom_range(0, 24);
            endcase
            wy = (p == 0) ? 3'd4 : $urandom_range(0, 7);
            write_reg(CFG_OFFSET_BITS, ($urandom & ~32'h1F) | 32'(off));
            write_reg(CFG_INDEX_MASK, msk);
            write_reg(CFG_WAYS_IN_USE, ($urandom & ~32'h7) | 32'(wy));
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_SPARE, $urandom);
            i_cfg_valid <= 1'b0;

            // odd entries share entry 0's low byte: conflicts in the default set map
            foreach (hot_addr[i]) begin
                hot_addr[i] = $urandom;
                if (i % 2)
                    hot_addr[i][7:0] = hot_addr[0][7:0];
            end

            repeat (PHASE_ITEMS) begin
                // now and then hold off until the pipe is empty
                if ($urandom_range(0, 99) == 0)
                    settle();
                issue_access(pick_address(), 1'b0, '0);
            end
        end

        settle();
        if (bad == 0 && lookups_owed.size() == 0)
            $display("set_assoc_cache_nru_lookup_unit: match");
        else
            $display("set_assoc_cache_nru_lookup_unit: mismatch");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("set_assoc_cache_nru_lookup_unit: mismatch");
        $finish;
    end

endmodule
